>>> hdl/ffca_pkg.sv
// ---------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants for the first-fit chunk allocator.
// ---------------------------------------------------------------------------
package ffca_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CFG_IW   = 2;

    localparam logic [LEN_W-1:0]  HDR_BYTES = 16'd2;
    localparam logic [LEN_W-1:0]  LEN_CAP   = 16'd65533;
    localparam logic [LEN_W-1:0]  LIMIT_RST = 16'd65533;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IW-1:0] CFG_REGION_START = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_REGION_END   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ALLOC_LIMIT  = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] chunk_start;
        logic [LEN_W-1:0]  chunk_len;
    } t_entry;

    localparam int unsigned ENTRY_W = ADDR_W + LEN_W;

endpackage

>>> hdl/ffca_ram.sv
// ---------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ffca_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/first_fit_chunk_allocator.sv
// Timing: an allocation refused for size or a full table, an allocation into an empty
// table or a free on an empty table goes straight to the done state, which loads the result
// register once the result channel is free; else the held chunks are walked (a scan to the
// insertion point or match, then any shift). One request at a time: o_stall holds until the
// result is registered, as the single-read-port table is walked entry by entry. Reset empties
// the table logically (count to zero, no clearing pass) and restores the configuration.
// ---------------------------------------------------------------------------
// first_fit_chunk_allocator
// Address-sorted chunk table with first-fit allocation and free by address.
// ---------------------------------------------------------------------------
module first_fit_chunk_allocator
    import ffca_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [ADDR_W-1:0]   i_cfg_data,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [LEN_W-1:0]    i_req_size,
    input  logic [ADDR_W-1:0]   i_free_addr,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_ok,
    output logic [ADDR_W-1:0]   o_payload_addr
);

    localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_TAIL = 3'd2;
    localparam logic [2:0] S_SHUP = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_SHDN = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // configuration
    logic [ADDR_W-1:0] r_region_start;
    logic [ADDR_W-1:0] r_region_end;
    logic [LEN_W-1:0]  r_alloc_limit;

    // control
    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_ptr, n_ptr;
    logic              r_more, n_more;
    logic              r_rd_vld, n_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    logic              r_out_valid, n_out_valid;

    // request context
    logic              r_op, n_op;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_target, n_target;
    logic [ADDR_W-1:0] r_prev_end, n_prev_end;
    logic [ADDR_W-1:0] r_new_start, n_new_start;
    logic [IW-1:0]     r_pos, n_pos;
    logic              r_res_ok, n_res_ok;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic              r_out_ok, n_out_ok;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;

    // memory port signals
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    t_entry            rd_entry;
    logic [ENTRY_W-1:0] rd_raw;
    logic              rd_issue;

    logic              in_acc;
    logic              out_free;
    logic [IW-1:0]     last_idx;
    logic [ADDR_W-1:0] cur_end;
    logic [ADDR_W-1:0] gap;
    logic [ADDR_W-1:0] tail_room;
    logic              size_bad;

    ffca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ptr),
        .o_rdata (rd_raw)
    );

    assign rd_entry  = t_entry'(rd_raw);
    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;
    assign last_idx  = IW'(r_count - CW'(1));
    assign cur_end   = rd_entry.chunk_start + {{(ADDR_W-LEN_W){1'b0}}, rd_entry.chunk_len};
    assign gap       = rd_entry.chunk_start - r_prev_end;
    assign tail_room = r_region_end - r_prev_end;
    assign size_bad  = (i_req_size > r_alloc_limit) || (i_req_size > LEN_CAP);
    assign rd_issue  = r_more && ((r_state == S_SCAN) || (r_state == S_SHUP)
                                  || (r_state == S_SHDN));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_more      = r_more;
        n_op        = r_op;
        n_len       = r_len;
        n_target    = r_target;
        n_prev_end  = r_prev_end;
        n_new_start = r_new_start;
        n_pos       = r_pos;
        n_res_ok    = r_res_ok;
        n_res_addr  = r_res_addr;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_addr  = r_out_addr;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;

        if (o_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        // The read pointer steps on every issued read but the last, which clears r_more instead of wrapping.
        if (rd_issue) begin
            if (r_state == S_SHUP) begin
                if (r_ptr == r_pos) begin
                    n_more = 1'b0;
                end else begin
                    n_ptr = r_ptr - IW'(1);
                end
            end else begin
                if (r_ptr == last_idx) begin
                    n_more = 1'b0;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op       = i_op;
                    n_len      = i_req_size + HDR_BYTES;
                    n_target   = i_free_addr - ADDR_W'(HDR_BYTES);
                    n_res_ok   = 1'b0;
                    n_res_addr = '0;
                    n_ptr      = '0;
                    n_more     = 1'b1;
                    if (i_op == OP_ALLOC) begin
                        if ((r_count == CW'(MAX_ENTRIES)) || size_bad) begin
                            n_state = S_DONE;
                        end else if (r_count == '0) begin
                            mem_we               = 1'b1;
                            mem_waddr            = '0;
                            mem_wdata.chunk_start = r_region_start;
                            mem_wdata.chunk_len  = i_req_size + HDR_BYTES;
                            n_count              = CW'(1);
                            n_res_ok             = 1'b1;
                            n_res_addr           = r_region_start + ADDR_W'(HDR_BYTES);
                            n_state              = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_rd_vld) begin
                    if (r_op == OP_FREE) begin
                        if (rd_entry.chunk_start == r_target) begin
                            n_res_ok = 1'b1;
                            if (r_rd_idx == last_idx) begin
                                n_count = r_count - CW'(1);
                                n_state = S_DONE;
                            end else begin
                                n_ptr   = r_rd_idx + IW'(1);
                                n_more  = 1'b1;
                                n_state = S_SHDN;
                            end
                        end else if (r_rd_idx == last_idx) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        if ((r_rd_idx != '0) && (gap >= {{(ADDR_W-LEN_W){1'b0}}, r_len})) begin
                            n_new_start = r_prev_end;
                            n_pos       = r_rd_idx;
                            n_ptr       = last_idx;
                            n_more      = 1'b1;
                            n_state     = S_SHUP;
                        end else begin
                            n_prev_end = cur_end;
                            if (r_rd_idx == last_idx) begin
                                n_state = S_TAIL;
                            end
                        end
                    end
                end
            end

            S_TAIL: begin
                if (tail_room >= {{(ADDR_W-LEN_W){1'b0}}, r_len}) begin
                    mem_we                = 1'b1;
                    mem_waddr             = IW'(r_count);
                    mem_wdata.chunk_start = r_prev_end;
                    mem_wdata.chunk_len   = r_len;
                    n_count               = r_count + CW'(1);
                    n_res_ok              = 1'b1;
                    n_res_addr            = r_prev_end + ADDR_W'(HDR_BYTES);
                end
                n_state = S_DONE;
            end

            S_SHUP: begin
                // Entries move up by one, highest first, to open the slot at r_pos.
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx + IW'(1);
                    mem_wdata = rd_entry;
                    if (r_rd_idx == r_pos) begin
                        n_state = S_INS;
                    end
                end
            end

            S_INS: begin
                mem_we                = 1'b1;
                mem_waddr             = r_pos;
                mem_wdata.chunk_start = r_new_start;
                mem_wdata.chunk_len   = r_len;
                n_count               = r_count + CW'(1);
                n_res_ok              = 1'b1;
                n_res_addr            = r_new_start + ADDR_W'(HDR_BYTES);
                n_state               = S_DONE;
            end

            S_SHDN: begin
                // Entries above the freed one move down by one, lowest first.
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx - IW'(1);
                    mem_wdata = rd_entry;
                    if (r_rd_idx == last_idx) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_addr  = r_res_addr;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A read still in flight when the state changes belongs to the old walk.
        n_rd_vld = rd_issue && (n_state == r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_ptr          <= '0;
            r_more         <= 1'b0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_region_start <= '0;
            r_region_end   <= '0;
            r_alloc_limit  <= LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_more      <= n_more;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REGION_START: r_region_start <= i_cfg_data;
                    CFG_REGION_END:   r_region_end   <= i_cfg_data;
                    CFG_ALLOC_LIMIT:  r_alloc_limit  <= i_cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= r_ptr;
        r_op        <= n_op;
        r_len       <= n_len;
        r_target    <= n_target;
        r_prev_end  <= n_prev_end;
        r_new_start <= n_new_start;
        r_pos       <= n_pos;
        r_res_ok    <= n_res_ok;
        r_res_addr  <= n_res_addr;
        r_out_ok    <= n_out_ok;
        r_out_addr  <= n_out_addr;
    end

    assign o_valid        = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_payload_addr = r_out_addr;

endmodule
